### design/wpcb_pkg.sv
// ----------------------------------------------------------------------------
// wpcb_pkg
// Shared types and constants for the white-patch colour balance block.
// ----------------------------------------------------------------------------
package wpcb_pkg;

    // Field widths of the pixel stream and the brightness register.
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 10;
    localparam int GAIN_W    = 12;
    localparam int FRAC_BITS = 8;

    // Datapath widths: S*b, p*S*b, 3*ref*2^F and the divider working width.
    localparam int SG_W   = SUM_W + GAIN_W;
    localparam int NUM_W  = PIX_W + SG_W;
    localparam int DEN3_W = PIX_W + 2;
    localparam int DEN_W  = DEN3_W + FRAC_BITS;
    // Quotient carries one extra bit that flags saturation.
    localparam int QUO_W  = PIX_W + 1;
    localparam int DIV_W  = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;

    // Divider schedule: a few quotient bits per clock.
    localparam int DIV_BITS_PER_CYC = 3;
    localparam int DIV_CYCLES       = (QUO_W + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC;
    localparam int DIV_CNT_W        = $clog2(DIV_CYCLES);

    localparam int NUM_LANES = 3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
    localparam logic [PIX_W-1:0]  PIX_MAX    = {PIX_W{1'b1}};

    // Pass codes.
    localparam logic PASS_MEASURE = 1'b0;
    localparam logic PASS_CORRECT = 1'b1;

    typedef struct packed {
        logic             pass_select;
        logic             frame_start;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
        logic             last_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             last_out;
    } t_pix_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIV,
        ST_FIN
    } t_state;

    // Control that the sequencer hands to every lane.
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

endpackage

### design/wpcb_lane.sv
// ----------------------------------------------------------------------------
// wpcb_lane
// One colour channel: forms p*S*b, then divides by 3*ref*2^F with a
// restoring divider that retires a few quotient bits per clock.
// ----------------------------------------------------------------------------
module wpcb_lane (
    input  logic                           i_clk,
    input  wpcb_pkg::t_lane_ctl            i_ctl,
    input  logic [wpcb_pkg::PIX_W-1:0]     i_pix,
    input  logic [wpcb_pkg::PIX_W-1:0]     i_ref,
    input  logic [wpcb_pkg::SG_W-1:0]      i_sg,
    output logic [wpcb_pkg::QUO_W-1:0]     o_quo
);

    logic [wpcb_pkg::DIV_W-1:0]  r_rem;
    logic [wpcb_pkg::DIV_W-1:0]  r_dsh;
    logic [wpcb_pkg::QUO_W-1:0]  r_quo;
    logic [wpcb_pkg::DIV_W-1:0]  n_rem;
    logic [wpcb_pkg::DIV_W-1:0]  n_dsh;
    logic [wpcb_pkg::QUO_W-1:0]  n_quo;
    logic [wpcb_pkg::NUM_W-1:0]  num;
    logic [wpcb_pkg::DEN3_W-1:0] den3;

    // Numerator and three times the reference.
    assign num  = wpcb_pkg::NUM_W'(i_pix) * wpcb_pkg::NUM_W'(i_sg);
    assign den3 = {i_ref, 1'b0} + wpcb_pkg::DEN3_W'(i_ref);

    // A few restoring steps: compare, subtract, shift the divisor down.
    always_comb begin
        n_rem = r_rem;
        n_dsh = r_dsh;
        n_quo = r_quo;
        for (int j = 0; j < wpcb_pkg::DIV_BITS_PER_CYC; j++) begin
            if (n_rem >= n_dsh) begin
                n_rem = n_rem - n_dsh;
                n_quo = {n_quo[wpcb_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[wpcb_pkg::QUO_W-2:0], 1'b0};
            end
            n_dsh = n_dsh >> 1;
        end
    end

    // Load the operands on the multiply cycle, then iterate.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= wpcb_pkg::DIV_W'(num);
            r_dsh <= wpcb_pkg::DIV_W'(den3) << (wpcb_pkg::FRAC_BITS + wpcb_pkg::QUO_W - 1);
            r_quo <= '0;
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_dsh <= n_dsh;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

### design/wpcb_merge.sv
// ----------------------------------------------------------------------------
// wpcb_merge
// Gathers the three lane quotients, applies saturation and the zero
// reference rule, and holds the finished pixel in the output register.
// ----------------------------------------------------------------------------
module wpcb_merge (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_load,
    input  logic [wpcb_pkg::NUM_LANES-1:0][wpcb_pkg::QUO_W-1:0] i_quo,
    input  logic [wpcb_pkg::NUM_LANES-1:0][wpcb_pkg::PIX_W-1:0] i_pix,
    input  logic [wpcb_pkg::NUM_LANES-1:0][wpcb_pkg::PIX_W-1:0] i_ref,
    input  logic                                             i_sum_nz,
    input  logic                                             i_last,
    input  logic                                             i_stall,
    output logic                                             o_free,
    output logic                                             o_valid,
    output wpcb_pkg::t_pix_out                               o_data
);

    logic                r_valid;
    wpcb_pkg::t_pix_out  r_data;
    wpcb_pkg::t_pix_out  n_data;
    logic [wpcb_pkg::NUM_LANES-1:0][wpcb_pkg::PIX_W-1:0] chan;

    // Per channel: zero reference, saturation, or the plain quotient.
    always_comb begin
        for (int k = 0; k < wpcb_pkg::NUM_LANES; k++) begin
            if (i_ref[k] == '0) begin
                chan[k] = (i_pix[k] != '0 && i_sum_nz) ? wpcb_pkg::PIX_MAX : '0;
            end else if (i_quo[k][wpcb_pkg::QUO_W-1]) begin
                chan[k] = wpcb_pkg::PIX_MAX;
            end else begin
                chan[k] = i_quo[k][wpcb_pkg::PIX_W-1:0];
            end
        end
        n_data.red_out   = chan[0];
        n_data.green_out = chan[1];
        n_data.blue_out  = chan[2];
        n_data.last_out  = i_last;
    end

    // The register may be loaded when empty or when its transaction completes.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### design/white_patch_color_balance.sv
// ----------------------------------------------------------------------------
// white_patch_color_balance
// White-patch colour balance over an RGB pixel stream sent twice.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/i_data/o_stall, output channel o_valid/o_data/
//   i_stall; a transaction completes when valid is high and stall is low.
//   Send the frame once with pass_select = 0 (frame_start on its first
//   pixel) to find the brightest pixel, then again with pass_select = 1.
//   Measure pixels are accepted one per cycle while the block is idle and give no result.
//   A correct pixel is registered, multiplied in the multiply state and
//   divided by three parallel channel lanes, three quotient bits per
//   cycle, in the divide state; the finish state then loads its result
//   into the output register, and only after that is the next pixel
//   taken, so the block does not overlap two correct pixels.
//   When the receiver stalls, the finished result waits in the output
//   register; the next pixel is still accepted and worked on, and stops
//   only when its own result is ready and the register is still full.
//   Reset clears the reference pixel and sets brightness_gain to 1.0.
//   i_cfg_wr_en writes brightness_gain; write it only while idle.
// ----------------------------------------------------------------------------
module white_patch_color_balance (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [wpcb_pkg::GAIN_W-1:0]        i_cfg_wr_data,
    input  logic                               i_valid,
    input  wpcb_pkg::t_pix_in                  i_data,
    output logic                               o_stall,
    output logic                               o_valid,
    output wpcb_pkg::t_pix_out                 o_data,
    input  logic                               i_stall
);

    logic [wpcb_pkg::GAIN_W-1:0]    r_gain;
    logic [wpcb_pkg::SUM_W-1:0]     r_best_sum;
    logic [wpcb_pkg::NUM_LANES-1:0][wpcb_pkg::PIX_W-1:0] r_ref;
    logic [wpcb_pkg::SG_W-1:0]      r_sg;
    logic [wpcb_pkg::NUM_LANES-1:0][wpcb_pkg::PIX_W-1:0] r_pix;
    logic                           r_last;
    wpcb_pkg::t_state               r_state;
    wpcb_pkg::t_state               n_state;
    logic [wpcb_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [wpcb_pkg::DIV_CNT_W-1:0] n_cnt;

    logic                           in_acc;
    logic [wpcb_pkg::SUM_W-1:0]     pix_sum;
    logic                           take_ref;
    logic                           out_free;
    logic                           out_load;
    wpcb_pkg::t_lane_ctl            lane_ctl;
    logic [wpcb_pkg::NUM_LANES-1:0][wpcb_pkg::PIX_W-1:0] in_pix;
    logic [wpcb_pkg::NUM_LANES-1:0][wpcb_pkg::QUO_W-1:0] lane_quo;

    assign in_acc = i_valid && !o_stall;
    assign in_pix = {i_data.blue_in, i_data.green_in, i_data.red_in};

    // Measure pass: keep the pixel with the largest sum since frame_start, later one on a tie.
    assign pix_sum  = wpcb_pkg::SUM_W'(i_data.red_in) + wpcb_pkg::SUM_W'(i_data.green_in)
                    + wpcb_pkg::SUM_W'(i_data.blue_in);
    assign take_ref = i_data.frame_start || (pix_sum >= r_best_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= wpcb_pkg::GAIN_RESET;
            r_best_sum <= '0;
            r_ref      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gain <= i_cfg_wr_data;
            end
            if (in_acc && i_data.pass_select == wpcb_pkg::PASS_MEASURE && take_ref) begin
                r_best_sum <= pix_sum;
                r_ref      <= in_pix;
            end
        end
    end

    // Reference sum times brightness, kept up to date every cycle.
    always_ff @(posedge i_clk) begin
        r_sg <= wpcb_pkg::SG_W'(r_best_sum) * wpcb_pkg::SG_W'(r_gain);
    end

    // Capture the pixel of a correct-pass transaction.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_data.pass_select == wpcb_pkg::PASS_CORRECT) begin
            r_pix  <= in_pix;
            r_last <= i_data.last_in;
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpcb_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Sequencer next state and lane control.
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        lane_ctl.load = 1'b0;
        lane_ctl.step = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            wpcb_pkg::ST_IDLE: begin
                if (in_acc && i_data.pass_select == wpcb_pkg::PASS_CORRECT) begin
                    n_state = wpcb_pkg::ST_MULT;
                end
            end
            wpcb_pkg::ST_MULT: begin
                lane_ctl.load = 1'b1;
                n_cnt         = '0;
                n_state       = wpcb_pkg::ST_DIV;
            end
            wpcb_pkg::ST_DIV: begin
                lane_ctl.step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == wpcb_pkg::DIV_CNT_W'(wpcb_pkg::DIV_CYCLES - 1)) begin
                    n_state = wpcb_pkg::ST_FIN;
                end
            end
            wpcb_pkg::ST_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = wpcb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wpcb_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != wpcb_pkg::ST_IDLE);

    // One lane per colour channel.
    for (genvar k = 0; k < wpcb_pkg::NUM_LANES; k++) begin : g_lane
        wpcb_lane u_lane (
            .i_clk (i_clk),
            .i_ctl (lane_ctl),
            .i_pix (r_pix[k]),
            .i_ref (r_ref[k]),
            .i_sg  (r_sg),
            .o_quo (lane_quo[k])
        );
    end

    wpcb_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_quo    (lane_quo),
        .i_pix    (r_pix),
        .i_ref    (r_ref),
        .i_sum_nz (r_best_sum != '0),
        .i_last   (r_last),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_data   (o_data)
    );

endmodule

### design/wpcb_checker.sv
// ----------------------------------------------------------------------------
// wpcb_checker
// Port-level checks on the white-patch colour balance block.
// ----------------------------------------------------------------------------
module wpcb_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  wpcb_pkg::t_pix_in           i_data,
    input  logic                        o_stall,
    input  logic                        o_valid,
    input  wpcb_pkg::t_pix_out          o_data,
    input  logic                        i_stall
);

    // A held result keeps its payload until its transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output result changed while stalled");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A correct-pass transaction occupies the block on the next cycle.
    a_corr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.pass_select == wpcb_pkg::PASS_CORRECT |=> o_stall)
        else $error("correct pixel did not occupy the block");

    // A measure-pass transaction leaves the block free for the next pixel.
    a_meas_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.pass_select == wpcb_pkg::PASS_MEASURE |=> !o_stall)
        else $error("measure pixel stalled the input");

    // A new result only appears at the end of a pixel's processing.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a pixel in flight");

endmodule

bind white_patch_color_balance wpcb_checker u_wpcb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_data  (i_data),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
